@@ rtl/wis_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wis_pkg
// Shared types and constants for the weighted index sampler.
// ============================================================================
package wis_pkg;

    localparam int WEIGHT_IN_W  = 32;
    localparam int UNIFORM_W    = 32;
    localparam int INDEX_OUT_W  = 5;
    localparam int MUL_W        = 32;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int S_TDATA_W    = WEIGHT_IN_W + UNIFORM_W;
    localparam int M_TDATA_W    = 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FIN,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic last;
        logic mul;
        logic mul_hi;
        logic fin;
        logic scan_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

@@ rtl/weighted_index_sampler_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// weighted_index_sampler_top
// Roulette-wheel selection over a loaded set of weights.
// ============================================================================
//  channel  | dir | fields
//  s_axis   | in  | tdata: weight[31:0], uniform[63:32]; tlast: last
//  m_axis   | out | tdata: chosen_index[4:0], overflow[5], zero[7:6]
//
//  Weights load one word per cycle while s_axis_tready is high. After the
//  last word come two partial products on one 32x32 multiplier plus one add,
//  N store reads (N = stored weights) with the read and the compare drained,
//  then the load of the output register that raises m_axis_tvalid.
//  Reset clears control state, count, total and overflow flag; the store is
//  not cleared. s_axis is held off during the multiply and scan, and while a
//  finished result waits for the previous one to leave m_axis; a result
//  waiting on m_axis does not stall loading of the next set.
// ============================================================================
module weighted_index_sampler_top #(
    parameter int MAX_BINS    = 32,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [wis_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // weight, uniform
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [wis_pkg::M_TDATA_W-1:0]   m_axis_tdata   // chosen_index, overflow
);

    wis_pkg::t_cmd                       cmd;
    wis_pkg::t_sts                       sts;
    logic [wis_pkg::INDEX_OUT_W-1:0]     index;
    logic                                overflow;

    wis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    wis_datapath #(
        .MAX_BINS    (MAX_BINS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_weight   (s_axis_tdata[wis_pkg::WEIGHT_IN_W-1:0]),
        .i_uniform  (s_axis_tdata[wis_pkg::S_TDATA_W-1:wis_pkg::WEIGHT_IN_W]),
        .o_sts      (sts),
        .o_index    (index),
        .o_overflow (overflow)
    );

    assign m_axis_tdata = {{(wis_pkg::M_TDATA_W - wis_pkg::INDEX_OUT_W - 1){1'b0}},
                           overflow, index};

    a_no_load_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_step |-> !s_axis_tready)
        else $error("input accepted during scan");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

    a_last_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken right after last word");

endmodule

@@ rtl/wis_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wis_ctrl
// Sequencer: load weights, run the scaled-total multiply, scan the store,
// hand the result to the output register.
// ============================================================================
module wis_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output wis_pkg::t_cmd o_cmd,
    input  wis_pkg::t_sts i_sts
);

    wis_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wis_pkg::ST_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            wis_pkg::ST_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.last = i_s_tlast;
                    if (i_s_tlast) begin
                        n_state = wis_pkg::ST_MUL_LO;
                    end
                end
            end
            wis_pkg::ST_MUL_LO: begin
                o_cmd.mul = 1'b1;
                n_state   = wis_pkg::ST_MUL_HI;
            end
            wis_pkg::ST_MUL_HI: begin
                o_cmd.mul    = 1'b1;
                o_cmd.mul_hi = 1'b1;
                n_state      = wis_pkg::ST_FIN;
            end
            wis_pkg::ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = wis_pkg::ST_SCAN;
            end
            wis_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = wis_pkg::ST_DONE;
                end
            end
            wis_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = wis_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = wis_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

@@ rtl/wis_datapath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wis_datapath
// Weight store, running total, shared 32x32 multiplier, prefix scan and
// result register.
// ============================================================================
module wis_datapath #(
    parameter int MAX_BINS    = 32,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wis_pkg::t_cmd                      i_cmd,
    input  logic [wis_pkg::WEIGHT_IN_W-1:0]    i_weight,
    input  logic [wis_pkg::UNIFORM_W-1:0]      i_uniform,
    output wis_pkg::t_sts                      o_sts,
    output logic [wis_pkg::INDEX_OUT_W-1:0]    o_index,
    output logic                               o_overflow
);

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int SUM_W = WEIGHT_BITS + IDX_W;
    localparam int MUL_W = wis_pkg::MUL_W;
    localparam int PROD_W = wis_pkg::PROD_W;

    logic [WEIGHT_BITS-1:0] mem [0:MAX_BINS-1];

    logic [WEIGHT_BITS-1:0] w;
    logic [CNT_W-1:0]       r_count;
    logic [SUM_W-1:0]       r_total;
    logic                   r_ovf;
    logic [MUL_W-1:0]       r_frac;
    logic [PROD_W-1:0]      r_prod;
    logic [MUL_W-1:0]       r_lo_hi;
    logic [SUM_W-1:0]       r_target;
    logic [CNT_W-1:0]       r_k;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [WEIGHT_BITS-1:0] r_rd_data;
    logic [SUM_W-1:0]       r_prefix;
    logic                   r_found;
    logic [IDX_W-1:0]       r_sel;
    logic [IDX_W-1:0]       r_out_idx;
    logic                   r_out_ovf;

    logic                   full;
    logic                   issue;
    logic [PROD_W-1:0]      total_ext;
    logic [MUL_W-1:0]       mul_a;
    logic [PROD_W-1:0]      mul_p;
    logic [PROD_W-1:0]      tgt_sum;
    logic [SUM_W-1:0]       prefix_nx;

    generate
        if (WEIGHT_BITS <= wis_pkg::WEIGHT_IN_W) begin : g_w_trunc
            assign w = i_weight[WEIGHT_BITS-1:0];
        end else begin : g_w_ext
            assign w = {{(WEIGHT_BITS - wis_pkg::WEIGHT_IN_W){1'b0}}, i_weight};
        end
        if (IDX_W >= wis_pkg::INDEX_OUT_W) begin : g_i_trunc
            assign o_index = r_out_idx[wis_pkg::INDEX_OUT_W-1:0];
        end else begin : g_i_ext
            assign o_index = {{(wis_pkg::INDEX_OUT_W - IDX_W){1'b0}}, r_out_idx};
        end
    endgenerate

    assign full      = (r_count >= CNT_W'(MAX_BINS));
    assign issue     = i_cmd.scan_step && (r_k < r_count);
    assign total_ext = PROD_W'(r_total);
    assign mul_a     = i_cmd.mul_hi ? total_ext[PROD_W-1:MUL_W] : total_ext[MUL_W-1:0];
    assign mul_p     = mul_a * r_frac;
    assign tgt_sum   = r_prod + PROD_W'(r_lo_hi);
    assign prefix_nx = r_prefix + SUM_W'(r_rd_data);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            mem[r_count[IDX_W-1:0]] <= w;
        end
        if (issue) begin
            r_rd_data <= mem[r_k[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_total  <= '0;
            r_ovf    <= 1'b0;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.load_out) begin
                r_count <= '0;
                r_total <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.load) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                    r_total <= r_total + SUM_W'(w);
                end
            end
            if (i_cmd.fin) begin
                r_k <= '0;
            end else if (issue) begin
                r_k <= r_k + 1'b1;
            end
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_cmd.last) begin
            r_frac <= i_uniform;
        end
        if (i_cmd.mul) begin
            r_prod <= mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_lo_hi <= r_prod[PROD_W-1:MUL_W];
        end
        if (i_cmd.fin) begin
            r_target <= tgt_sum[SUM_W-1:0];
            r_prefix <= '0;
            r_found  <= 1'b0;
            r_sel    <= '0;
        end else if (r_rd_vld) begin
            r_prefix <= prefix_nx;
            if (!r_found && (r_target < prefix_nx)) begin
                r_found <= 1'b1;
                r_sel   <= r_rd_idx;
            end
        end
        if (issue) begin
            r_rd_idx <= r_k[IDX_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_idx <= r_sel;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_sts.scan_done = (r_k >= r_count) && !r_rd_vld;
    assign o_overflow      = r_out_ovf;

endmodule
